// ===== rtl/sphere_pairwise_coulomb_energy_defines.svh =====
// Assertion macros for the sphere pairwise Coulomb energy block
`ifndef SPHERE_PAIRWISE_COULOMB_ENERGY_DEFINES_SVH
`define SPHERE_PAIRWISE_COULOMB_ENERGY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/spce_pkg.sv =====
// Shared types and constants for the sphere pairwise Coulomb energy block
`default_nettype none
package spce_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CORDIC_ITERS = 30;
  localparam int SQ_STEPS    = 3;
  localparam int SQRT_STEPS  = 19;
  localparam int DIV_STEPS   = 34;

  localparam int AWID = 36;   // CORDIC angle/vector width, Q30 with headroom

  localparam logic signed [AWID-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [AWID-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [AWID-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [AWID-1:0] Q30_GAIN    = 36'sd652032874;

  localparam logic [37:0] ENERGY_MAX = 38'h3F_FFFF_FFFF;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DROP,
    OP_INIT_TH,
    OP_CORDIC_STEP,
    OP_SAVE_TH,
    OP_SAVE_AZ,
    OP_MUL_X,
    OP_MUL_Y,
    OP_STORE,
    OP_PAIR_INIT,
    OP_READ,
    OP_DIFF,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] iter;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic has_pair;
    logic last_pair;
  } status_t;

  function automatic logic signed [AWID-1:0] atan_q30(input logic [5:0] idx);
    logic signed [AWID-1:0] v;
    begin
      case (idx)
        6'd0:    v = 36'sd843314857;
        6'd1:    v = 36'sd497837829;
        6'd2:    v = 36'sd263043837;
        6'd3:    v = 36'sd133525159;
        6'd4:    v = 36'sd67021687;
        6'd5:    v = 36'sd33543516;
        6'd6:    v = 36'sd16775851;
        6'd7:    v = 36'sd8388437;
        6'd8:    v = 36'sd4194283;
        6'd9:    v = 36'sd2097149;
        default: v = (idx < 6'd30) ? (36'sd1 <<< (6'd30 - idx)) : 36'sd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sphere_pairwise_coulomb_energy.sv =====
// Top level of the sphere pairwise Coulomb energy block
// Load: each particle, from the start transfer on, runs two 30-step CORDIC passes,
//   one shared 18x18 multiplier for x and y and one store write; busy is high meanwhile.
// Sum: after the last particle is loaded, each pair runs a 3-step square sum, a 19-step
//   square root and a 34-step divider before the result strobe.
// The result is shown for one cycle with out_valid; the receiver cannot stall it.
// Reset (rst_n low, synchronous) clears the count, energy, flags and sequencer.
`default_nettype none
`include "sphere_pairwise_coulomb_energy_defines.svh"
module sphere_pairwise_coulomb_energy #(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [17:0]        in_theta_angle,
  input  wire logic signed [18:0] in_azimuth_angle,
  input  wire logic               in_last_particle,
  output logic                    out_valid,
  output logic [37:0]             out_energy,
  output logic [6:0]              out_particle_count,
  output logic                    out_overflowed
);
  import spce_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one transfer per idle start, then walks load and sum phases
  spce_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_last_particle (in_last_particle),
    .status           (status),
    .cmd              (cmd),
    .busy             (busy),
    .out_valid        (out_valid)
  );

  // datapath: CORDIC, coordinate store, pair arithmetic, accumulator
  spce_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_theta_angle     (in_theta_angle),
    .in_azimuth_angle   (in_azimuth_angle),
    .status             (status),
    .out_energy         (out_energy),
    .out_particle_count (out_particle_count),
    .out_overflowed     (out_overflowed)
  );

  // a result strobe lasts one cycle
  `SPCE_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held")
  // an accepted transfer makes the block busy
  `SPCE_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy missing after start")
  // no new transfer while a result is shown
  `SPCE_ASSERT_NOW(a_busy_on_result, out_valid, busy, "idle during result")

endmodule
`default_nettype wire

// ===== rtl/spce_ctrl.sv =====
// Sequencer for particle load and pairwise energy sum
`default_nettype none
module spce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_last_particle,
  input  spce_pkg::status_t      status,
  output spce_pkg::cmd_t         cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import spce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_CORD_TH, S_SAVE_TH, S_CORD_AZ, S_SAVE_AZ,
    S_MUL_X, S_MUL_Y, S_STORE, S_SUM, S_READ, S_DIFF, S_SQ,
    S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_ACC, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] iter_r, iter_nxt;
  logic       last_r, last_nxt;
  logic       busy_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = 6'd0;
    last_nxt  = last_r;
    cmd.op    = OP_NONE;
    cmd.iter  = iter_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_CAPTURE;
          last_nxt  = in_last_particle;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.full) begin
          cmd.op    = OP_DROP;
          state_nxt = last_r ? S_SUM : S_IDLE;
        end else begin
          cmd.op    = OP_INIT_TH;
          state_nxt = S_CORD_TH;
        end
      end
      S_CORD_TH: begin
        cmd.op = OP_CORDIC_STEP;
        if (iter_r == 6'(CORDIC_ITERS - 1)) state_nxt = S_SAVE_TH;
        else iter_nxt = iter_r + 6'd1;
      end
      S_SAVE_TH: begin
        cmd.op    = OP_SAVE_TH;
        state_nxt = S_CORD_AZ;
      end
      S_CORD_AZ: begin
        cmd.op = OP_CORDIC_STEP;
        if (iter_r == 6'(CORDIC_ITERS - 1)) state_nxt = S_SAVE_AZ;
        else iter_nxt = iter_r + 6'd1;
      end
      S_SAVE_AZ: begin
        cmd.op    = OP_SAVE_AZ;
        state_nxt = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.op    = OP_MUL_X;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.op    = OP_MUL_Y;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op    = OP_STORE;
        state_nxt = last_r ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        if (status.has_pair) begin
          cmd.op    = OP_PAIR_INIT;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (iter_r == 6'(SQ_STEPS - 1)) state_nxt = S_SQRT_INIT;
        else iter_nxt = iter_r + 6'd1;
      end
      S_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (iter_r == 6'(SQRT_STEPS - 1)) state_nxt = S_DIV_INIT;
        else iter_nxt = iter_r + 6'd1;
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (iter_r == 6'(DIV_STEPS - 1)) state_nxt = S_ACC;
        else iter_nxt = iter_r + 6'd1;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = status.last_pair ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= 6'd0;
      last_r      <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      last_r      <= last_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_EMIT);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/spce_datapath.sv =====
// CORDIC, coordinate store, square root, divider and energy accumulator
`default_nettype none
module spce_datapath #(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  spce_pkg::cmd_t           cmd,
  input  wire logic [17:0]         in_theta_angle,
  input  wire logic signed [18:0]  in_azimuth_angle,
  output spce_pkg::status_t        status,
  output logic [37:0]              out_energy,
  output logic [6:0]               out_particle_count,
  output logic                     out_overflowed
);
  import spce_pkg::*;

  localparam int CNTW = $clog2(MAX_PARTICLES + 1);
  localparam int AW   = $clog2(MAX_PARTICLES);

  // captured angles
  logic [17:0]        th_r;
  logic signed [18:0] az_r;

  // CORDIC state
  logic signed [AWID-1:0] cx_r, cy_r, cz_r;
  logic                   neg_r;

  logic signed [17:0] ct_r, st_r, cp_r, sp_r, xq_r;
  logic signed [35:0] prod_r;

  // coordinate store: {x, y, z}
  logic [53:0] mem [MAX_PARTICLES];
  logic [53:0] ap_r, bp_r;

  logic [CNTW-1:0] cnt_r;
  logic [AW-1:0]   i_r, j_r;
  logic            drop_r, sat_r;

  logic signed [18:0] dx_r, dy_r, dz_r;
  logic [36:0]        d2_r;
  logic [37:0]        v_r, res_r;
  logic [33:0]        num_r, q_r;
  logic [19:0]        rem_r;
  logic [18:0]        dvs_r;
  logic [37:0]        energy_r;

  function automatic logic signed [17:0] q30_to_fb(input logic signed [AWID-1:0] v);
    logic signed [AWID:0] t;
    begin
      t = ($signed({v[AWID-1], v}) + (37'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (t > 37'sd65536) t = 37'sd65536;
      if (t < -37'sd65536) t = -37'sd65536;
      return t[17:0];
    end
  endfunction

  // angle reduction for the CORDIC start
  logic signed [AWID-1:0] ang, red, fold;
  logic                   fold_neg;
  always_comb begin
    if (cmd.op == OP_SAVE_TH) ang = AWID'(az_r) <<< (30 - FRAC_BITS);
    else ang = $signed({18'd0, th_r}) <<< (30 - FRAC_BITS);
    if (ang > Q30_PI) red = ang - Q30_TWO_PI;
    else if (ang < -Q30_PI) red = ang + Q30_TWO_PI;
    else red = ang;
    fold_neg = 1'b0;
    fold     = red;
    if (red > Q30_HALF_PI) begin
      fold     = red - Q30_PI;
      fold_neg = 1'b1;
    end else if (red < -Q30_HALF_PI) begin
      fold     = red + Q30_PI;
      fold_neg = 1'b1;
    end
  end

  logic signed [AWID-1:0] sx, sy, fx, fy;
  assign sx = cx_r >>> cmd.iter;
  assign sy = cy_r >>> cmd.iter;
  assign fx = neg_r ? -cx_r : cx_r;
  assign fy = neg_r ? -cy_r : cy_r;

  logic signed [35:0] rnd;
  assign rnd = (prod_r + 36'sd32768) >>> FRAC_BITS;

  logic signed [18:0] sq_sel;
  logic signed [37:0] sq;
  always_comb begin
    case (cmd.iter[1:0])
      2'd0:    sq_sel = dx_r;
      2'd1:    sq_sel = dy_r;
      default: sq_sel = dz_r;
    endcase
    sq = sq_sel * sq_sel;
  end

  logic [37:0] sbit, trial;
  logic [6:0]  sshift;
  assign sshift = 7'd36 - {cmd.iter, 1'b0};
  assign sbit   = 38'd1 << sshift;
  assign trial  = res_r + sbit;

  logic [19:0] rem_sh;
  assign rem_sh = {rem_r[18:0], num_r[33]};

  logic [37:0] term;
  assign term = {4'd0, q_r};

  // coordinate store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) mem[cnt_r[AW-1:0]] <= {xq_r, rnd[17:0], ct_r};
    if (cmd.op == OP_READ) begin
      ap_r <= mem[i_r];
      bp_r <= mem[j_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      drop_r   <= 1'b0;
      sat_r    <= 1'b0;
      energy_r <= '0;
    end else begin
      case (cmd.op)
        OP_DROP:  drop_r <= 1'b1;
        OP_STORE: cnt_r  <= cnt_r + CNTW'(1);
        OP_ACC: begin
          if (term > ENERGY_MAX - energy_r) begin
            energy_r <= ENERGY_MAX;
            sat_r    <= 1'b1;
          end else begin
            energy_r <= energy_r + term;
          end
        end
        OP_CLEAR: begin
          cnt_r    <= '0;
          drop_r   <= 1'b0;
          sat_r    <= 1'b0;
          energy_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        th_r <= in_theta_angle;
        az_r <= in_azimuth_angle;
      end
      OP_INIT_TH: begin
        cx_r  <= Q30_GAIN;
        cy_r  <= '0;
        cz_r  <= fold;
        neg_r <= fold_neg;
      end
      OP_CORDIC_STEP: begin
        if (!cz_r[AWID-1]) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          cz_r <= cz_r - atan_q30(cmd.iter);
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          cz_r <= cz_r + atan_q30(cmd.iter);
        end
      end
      OP_SAVE_TH: begin
        ct_r  <= q30_to_fb(fx);
        st_r  <= q30_to_fb(fy);
        cx_r  <= Q30_GAIN;
        cy_r  <= '0;
        cz_r  <= fold;
        neg_r <= fold_neg;
      end
      OP_SAVE_AZ: begin
        cp_r <= q30_to_fb(fx);
        sp_r <= q30_to_fb(fy);
      end
      OP_MUL_X: prod_r <= st_r * cp_r;
      OP_MUL_Y: begin
        xq_r   <= rnd[17:0];
        prod_r <= st_r * sp_r;
      end
      OP_PAIR_INIT: begin
        i_r <= '0;
        j_r <= AW'(1);
      end
      OP_DIFF: begin
        dx_r <= $signed({ap_r[53], ap_r[53:36]}) - $signed({bp_r[53], bp_r[53:36]});
        dy_r <= $signed({ap_r[35], ap_r[35:18]}) - $signed({bp_r[35], bp_r[35:18]});
        dz_r <= $signed({ap_r[17], ap_r[17:0]}) - $signed({bp_r[17], bp_r[17:0]});
        d2_r <= '0;
      end
      OP_SQ: d2_r <= d2_r + sq[36:0];
      OP_SQRT_INIT: begin
        v_r   <= (d2_r == 37'd0) ? 38'd1 : {1'b0, d2_r};
        res_r <= '0;
      end
      OP_SQRT_STEP: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + sbit;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      OP_DIV_INIT: begin
        num_r <= (34'd1 << (2 * FRAC_BITS)) + {16'd0, res_r[18:1]};
        dvs_r <= res_r[18:0];
        rem_r <= '0;
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= rem_sh - {1'b0, dvs_r};
          q_r   <= {q_r[32:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[32:0], 1'b0};
        end
      end
      OP_ACC: begin
        if (CNTW'(j_r) == cnt_r - CNTW'(1)) begin
          i_r <= i_r + AW'(1);
          j_r <= i_r + AW'(2);
        end else begin
          j_r <= j_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign status.full      = (cnt_r == CNTW'(MAX_PARTICLES));
  assign status.has_pair  = (cnt_r >= CNTW'(2));
  assign status.last_pair = (CNTW'(j_r) == cnt_r - CNTW'(1)) &&
                            (CNTW'(i_r) == cnt_r - CNTW'(2));

  assign out_energy         = energy_r;
  assign out_particle_count = 7'(cnt_r);
  assign out_overflowed     = sat_r | drop_r;

endmodule
`default_nettype wire
